@@ rtl/core/clvt_pkg.sv @@
// ----------------------------------------------------------------------------
// clvt_pkg
// sizes, field widths and result codes of the checksum learn-and-verify table
// ----------------------------------------------------------------------------
`default_nettype none

package clvt_pkg;

  localparam int NUM_USERS = 1024;
  localparam int NUM_FUNCS = 16;
  localparam int SAMPLES   = 8;

  // field widths
  localparam int USER_W   = 10;
  localparam int FUNC_W   = 6;
  localparam int CSUM_W   = 32;
  localparam int STATUS_W = 3;

  // stream beat widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;

  // derived storage sizes
  localparam int SLOT_DEPTH = NUM_USERS * NUM_FUNCS;
  localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int RING_DEPTH = NUM_FUNCS * SAMPLES;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FIDX_W     = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int POS_W      = $clog2(SAMPLES);
  localparam int CNT_W      = $clog2(SAMPLES + 1);
  localparam int WALK_MAX   = (SAMPLES > NUM_FUNCS) ? SAMPLES : NUM_FUNCS;
  localparam int WALK_W     = $clog2(WALK_MAX + 1);

  // command codes
  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_AUDIT  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_ACCEPTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_MISMATCH   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EXEMPT     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_AUDIT_PASS = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_AUDIT_FAIL = 3'd5;

endpackage

`default_nettype wire

@@ rtl/core/checksum_learn_and_verify_table.sv @@
// ----------------------------------------------------------------------------
// checksum_learn_and_verify_table
// learns one reference checksum per function slot, then verifies reports
// ----------------------------------------------------------------------------
// After reset the block first runs a clearing pass over the user slot memory,
// one slot per cycle; s_axis_tready stays low until it ends, while
// configuration beats are taken at any time. The block then handles one
// command at a time under a small sequencer, with one walk counter stepping
// through the memories:
//   report, plain                  : REPORT state, then FINISH
//   report that fills a sample ring: REPORT, LEARN, FINISH; the consensus
//                                    check reads one ring entry per cycle
//   audit                          : AUDIT, then FINISH; one user slot
//                                    read and cleared per cycle
//   invalid slot or exempt audit   : to FINISH, an invalid one via REPORT
// The result beat sits in an output register, so a new command is taken while
// the previous result still waits on m_axis_tready. disconnect_enable is set
// through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module checksum_learn_and_verify_table
  import clvt_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  // command beats
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // [9:0] user_index, [15:10] function_index, [47:16] checksum_value,
  // [48] user_exempt, [55:49] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  wire logic                   s_axis_tuser,

  // result beats
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [2:0] status, [3] disconnect_request, [4] all_learned, [7:5] zero
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,

  // register write: disconnect_enable
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic                   cfg_data_i
);

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_REPORT = 3'd2;
  localparam logic [2:0] ST_LEARN  = 3'd3;
  localparam logic [2:0] ST_AUDIT  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_q, state_d;

  // latched command
  logic [USER_W-1:0] user_q, user_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [CSUM_W-1:0] value_q, value_d;
  logic              exempt_q, exempt_d;

  // per-function learning state
  logic [CNT_W-1:0]  count_q [NUM_FUNCS];
  logic [CNT_W-1:0]  count_d [NUM_FUNCS];
  logic [POS_W-1:0]  pos_q   [NUM_FUNCS];
  logic [POS_W-1:0]  pos_d   [NUM_FUNCS];
  logic [CSUM_W-1:0] ref_q   [NUM_FUNCS];
  logic [CSUM_W-1:0] ref_d   [NUM_FUNCS];
  logic [NUM_FUNCS-1:0] learned_q, learned_d;

  // walk control shared by consensus check and audit
  logic [WALK_W-1:0] walk_q, walk_d;
  logic              pend_q, pend_d;
  logic              first_tag_q, first_tag_d;
  logic [CSUM_W-1:0] first_val_q, first_val_d;
  logic [CNT_W-1:0]  hits_q, hits_d;
  logic              missing_q, missing_d;

  // result being built
  logic [STATUS_W-1:0] status_q, status_d;
  logic                fail_q, fail_d;

  // clearing pass
  logic [SLOT_AW-1:0] clr_q, clr_d;

  logic disc_en_q;

  // output register
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // user slot memory
  logic [CSUM_W-1:0]  slot_mem [SLOT_DEPTH];
  logic               slot_we;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [CSUM_W-1:0]  slot_wdata, slot_rdata_q;

  // sample ring memory
  logic [CSUM_W-1:0]  ring_mem [RING_DEPTH];
  logic               ring_we;
  logic [RING_AW-1:0] ring_waddr, ring_raddr;
  logic [CSUM_W-1:0]  ring_rdata_q;

  // derived
  logic [FIDX_W-1:0]  fidx;
  logic               func_ok, user_ok, all_learned;
  logic [SLOT_AW-1:0] slot_base;
  logic [RING_AW-1:0] ring_base;
  logic               in_beat, out_free;
  logic [CNT_W-1:0]   cnt_new;
  logic               in_user_ok;

  assign fidx        = func_q[FIDX_W-1:0];
  assign func_ok     = (int'(func_q) < NUM_FUNCS);
  assign user_ok     = (int'(user_q) < NUM_USERS);
  assign in_user_ok  = (int'(s_axis_tdata[USER_W-1:0]) < NUM_USERS);
  assign all_learned = &learned_q;
  assign slot_base   = SLOT_AW'(int'(user_q) * NUM_FUNCS);
  assign ring_base   = RING_AW'(int'(fidx) * SAMPLES);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d     = state_q;
    user_d      = user_q;
    func_d      = func_q;
    value_d     = value_q;
    exempt_d    = exempt_q;
    count_d     = count_q;
    pos_d       = pos_q;
    ref_d       = ref_q;
    learned_d   = learned_q;
    walk_d      = walk_q;
    pend_d      = 1'b0;
    first_tag_d = 1'b0;
    first_val_d = first_val_q;
    hits_d      = hits_q;
    missing_d   = missing_q;
    status_d    = status_q;
    fail_d      = fail_q;
    clr_d       = clr_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    cnt_new     = count_q[fidx];

    slot_we     = 1'b0;
    slot_waddr  = slot_base + SLOT_AW'(fidx);
    slot_wdata  = value_q;
    slot_raddr  = slot_base + SLOT_AW'(walk_q);
    ring_we     = 1'b0;
    ring_waddr  = ring_base + RING_AW'(pos_q[fidx]);
    ring_raddr  = ring_base + RING_AW'(walk_q);

    unique case (state_q)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + SLOT_AW'(1);
        if (int'(clr_q) == SLOT_DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_beat) begin
          user_d    = s_axis_tdata[USER_W-1:0];
          func_d    = s_axis_tdata[USER_W +: FUNC_W];
          value_d   = s_axis_tdata[USER_W+FUNC_W +: CSUM_W];
          exempt_d  = s_axis_tdata[USER_W+FUNC_W+CSUM_W];
          fail_d    = 1'b0;
          walk_d    = '0;
          hits_d    = '0;
          // out-of-range users have no slots and read as all zero
          missing_d = !in_user_ok;
          if (s_axis_tuser == CMD_REPORT) begin
            state_d = ST_REPORT;
          end else if (exempt_d) begin
            status_d = STAT_EXEMPT;
            state_d  = ST_FINISH;
          end else begin
            state_d = ST_AUDIT;
          end
        end
      end

      ST_REPORT: begin
        state_d = ST_FINISH;
        if (!func_ok) begin
          status_d = STAT_INVALID;
        end else begin
          if (exempt_q) begin
            status_d = STAT_EXEMPT;
          end else if (!all_learned || ref_q[fidx] == value_q) begin
            slot_we  = user_ok;
            status_d = STAT_ACCEPTED;
          end else begin
            status_d = STAT_MISMATCH;
            fail_d   = 1'b1;
          end
          // unlearned function: feed the sample ring
          if (!all_learned && !learned_q[fidx]) begin
            ring_we = 1'b1;
            pos_d[fidx] = (int'(pos_q[fidx]) + 1 >= SAMPLES) ? '0
                                                              : pos_q[fidx] + POS_W'(1);
            if (int'(count_q[fidx]) < SAMPLES) begin
              cnt_new = count_q[fidx] + CNT_W'(1);
            end
            count_d[fidx] = cnt_new;
            if (int'(cnt_new) >= SAMPLES) begin
              state_d = ST_LEARN;
            end
          end
        end
      end

      ST_LEARN: begin
        // issue one ring read per cycle, compare the returned entry
        if (int'(walk_q) < SAMPLES) begin
          walk_d      = walk_q + WALK_W'(1);
          pend_d      = 1'b1;
          first_tag_d = (walk_q == '0);
        end
        if (pend_q) begin
          if (first_tag_q) begin
            first_val_d = ring_rdata_q;
            hits_d      = CNT_W'(1);
          end else if (ring_rdata_q == first_val_q) begin
            hits_d = hits_q + CNT_W'(1);
          end
        end
        if (int'(walk_q) == SAMPLES && !pend_q) begin
          if (int'(hits_q) >= SAMPLES - 1) begin
            learned_d[fidx] = 1'b1;
            ref_d[fidx]     = first_val_q;
          end
          state_d = ST_FINISH;
        end
      end

      ST_AUDIT: begin
        // read and clear one slot per cycle
        if (int'(walk_q) < NUM_FUNCS) begin
          walk_d     = walk_q + WALK_W'(1);
          pend_d     = 1'b1;
          slot_we    = user_ok;
          slot_waddr = slot_raddr;
          slot_wdata = '0;
        end
        if (pend_q && user_ok && slot_rdata_q == '0) begin
          missing_d = 1'b1;
        end
        if (int'(walk_q) == NUM_FUNCS && !pend_q) begin
          status_d = missing_q ? STAT_AUDIT_FAIL : STAT_AUDIT_PASS;
          fail_d   = missing_q;
          state_d  = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {(OUT_TDATA_W-STATUS_W-2)'(0), all_learned,
                       fail_q && disc_en_q, status_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and learning state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      learned_q <= '0;
      walk_q    <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
      disc_en_q <= 1'b0;
      for (int i = 0; i < NUM_FUNCS; i++) begin
        count_q[i] <= '0;
        pos_q[i]   <= '0;
        ref_q[i]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      learned_q <= learned_d;
      walk_q    <= walk_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      ref_q     <= ref_d;
      if (cfg_valid_i && cfg_ready_o) begin
        disc_en_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    user_q      <= user_d;
    func_q      <= func_d;
    value_q     <= value_d;
    exempt_q    <= exempt_d;
    first_tag_q <= first_tag_d;
    first_val_q <= first_val_d;
    hits_q      <= hits_d;
    missing_q   <= missing_d;
    status_q    <= status_d;
    fail_q      <= fail_d;
    m_data_q    <= m_data_d;
  end

  // user slot memory, read data registered, old data on same-address write
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata_q <= slot_mem[slot_raddr];
  end

  // sample ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= value_q;
    end
    ring_rdata_q <= ring_mem[ring_raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/clvt_checker.sv @@
// ----------------------------------------------------------------------------
// clvt_checker
// port-level checks of the checksum learn-and-verify table
// ----------------------------------------------------------------------------
`default_nettype none

module clvt_checker
  import clvt_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] status;
  logic                disc;
  logic                learned;
  logic                out_beat;
  logic                seen_all_q;

  assign status   = m_axis_tdata[STATUS_W-1:0];
  assign disc     = m_axis_tdata[STATUS_W];
  assign learned  = m_axis_tdata[STATUS_W+1];
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // remembers that a delivered beat already reported all functions learned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_all_q <= 1'b0;
    end else if (out_beat && learned) begin
      seen_all_q <= 1'b1;
    end
  end

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // only defined status codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> status <= STAT_AUDIT_FAIL)
    else $error("undefined status code");

  // disconnect only on a failing result
  a_disc_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && disc |-> status == STAT_MISMATCH || status == STAT_AUDIT_FAIL)
    else $error("disconnect without failure");

  // mismatch can only be flagged once every reference is learned
  a_mismatch_learned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status == STAT_MISMATCH |-> learned)
    else $error("mismatch before learning finished");

  // learned state never falls back
  a_learned_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_all_q |-> learned)
    else $error("all_learned dropped");

endmodule

bind checksum_learn_and_verify_table clvt_checker u_clvt_checker (.*);

`default_nettype wire
